### src/sidc_pkg.sv
// Package for the signed integer to decimal text converter.
// Holds the controller state type, command/status structs and character constants.
// No dependencies.
`default_nettype none

package sidc_pkg;

    localparam logic [7:0]  CHAR_ZERO   = 8'd48;
    localparam logic [7:0]  CHAR_MINUS  = 8'd45;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit unsigned x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_first;
        logic dig_step;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic q_zero;
        logic negative;
        logic ptr_zero;
    } status_t;

    // decimal digits needed for the magnitude 2^(w-1)
    function automatic int digit_count(input int w);
        longint lim;
        longint p;
        int     n;
        lim = longint'(1) << (w - 1);
        p   = 10;
        n   = 1;
        for (int i = 0; i < 12; i++) begin
            if (p <= lim) begin
                n = n + 1;
                p = p * 10;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### src/signed_int_to_decimal_chars_top.sv
// Top level of the signed integer to decimal text converter.
// Depends on sidc_pkg, sidc_ctrl and sidc_datapath.
//
//  channel   ports                  handshake
//  input     value                  beat taken when start && !busy
//  result    char_code, last        one beat per cycle with strobe high
//
// While busy is high the converter runs a first multiply step, then one digit per cycle
// through the divide-by-ten multiplier, a minus sign if negative, then one character
// per cycle from the digit store.
// The last character appears in the cycle busy falls; a new start is taken then.
// Reset clears the controller and the strobe; results cannot be stalled.
`default_nettype none

module signed_int_to_decimal_chars_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    output logic                               busy,
    output logic                               strobe,
    output logic             [7:0]             char_code,
    output logic                               last
);

    sidc_pkg::cmd_t    cmd;
    sidc_pkg::status_t status;

    sidc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sidc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .char_code (char_code),
        .last      (last),
        .strobe    (strobe)
    );

endmodule

`default_nettype wire

### src/sidc_ctrl.sv
// Controller FSM for the decimal text converter.
// Depends on sidc_pkg (state_t, cmd_t, status_t).
`default_nettype none

module sidc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sidc_pkg::status_t status,
    output sidc_pkg::cmd_t         cmd,
    output logic                   busy
);

    sidc_pkg::state_t state_reg;
    sidc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sidc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            sidc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sidc_pkg::ST_MUL;
                end
            end
            sidc_pkg::ST_MUL:
            begin
                cmd.mul_first = 1'b1;
                state_next    = sidc_pkg::ST_DIG;
            end
            sidc_pkg::ST_DIG:
            begin
                cmd.dig_step = 1'b1;
                if (status.q_zero)
                begin
                    state_next = status.negative ? sidc_pkg::ST_SIGN : sidc_pkg::ST_EMIT;
                end
            end
            sidc_pkg::ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = sidc_pkg::ST_EMIT;
            end
            sidc_pkg::ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.ptr_zero)
                begin
                    state_next = sidc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sidc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sidc_datapath.sv
// Datapath: magnitude, divide-by-ten reciprocal multiplier, digit store, output beat.
// Depends on sidc_pkg (cmd_t, status_t, constants, digit_count).
`default_nettype none

module sidc_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire sidc_pkg::cmd_t                cmd,
    output sidc_pkg::status_t                  status,
    output logic             [7:0]             char_code,
    output logic                               last,
    output logic                               strobe
);

    localparam int MAX_DIGITS = sidc_pkg::digit_count(VALUE_WIDTH);
    localparam int PTR_W      = $clog2(MAX_DIGITS);
    localparam int Q_W        = 64 - sidc_pkg::RECIP_SHIFT;

    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] m_reg;
    logic [VALUE_WIDTH-1:0] m_next;
    logic [63:0]            prod_reg;
    logic [63:0]            prod_next;
    logic [PTR_W-1:0]       ptr_reg;
    logic [3:0]             digits_reg [MAX_DIGITS];
    logic [7:0]             char_reg;
    logic                   last_reg;
    logic                   strobe_reg;

    logic [Q_W-1:0]         q;
    logic [VALUE_WIDTH-1:0] q_trunc;
    logic [VALUE_WIDTH-1:0] mul_in;
    logic [3:0]             ten_q;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] mag;

    assign mag     = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    assign q       = prod_reg[63:sidc_pkg::RECIP_SHIFT];
    assign q_trunc = VALUE_WIDTH'(q);
    // digit = m - 10*q, only the low nibble matters
    assign ten_q   = {q[0], 3'b000} + {q[2:0], 1'b0};
    assign digit   = m_reg[3:0] - ten_q;

    assign mul_in    = cmd.mul_first ? m_reg : q_trunc;
    assign prod_next = 64'(32'(mul_in)) * 64'(sidc_pkg::RECIP_10);
    assign m_next    = cmd.load ? mag : q_trunc;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[VALUE_WIDTH-1];
        end
        if (cmd.load || cmd.dig_step)
        begin
            m_reg <= m_next;
        end
        if (cmd.mul_first || cmd.dig_step)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.dig_step)
        begin
            digits_reg[ptr_reg] <= digit;
        end
        if (cmd.emit_sign)
        begin
            char_reg <= sidc_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sidc_pkg::CHAR_ZERO + {4'b0000, digits_reg[ptr_reg]};
            last_reg <= (ptr_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign || cmd.emit_digit;
            if (cmd.load)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.dig_step && !status.q_zero)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            else if (cmd.emit_digit && ptr_reg != '0)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end
        end
    end

    assign status.q_zero   = (q == '0);
    assign status.negative = neg_reg;
    assign status.ptr_zero = (ptr_reg == '0);

    assign char_code = char_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

endmodule

`default_nettype wire

### src/sidc_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
// Depends on signed_int_to_decimal_chars_top port names and sidc_pkg character constants.
`default_nettype none

module sidc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       strobe,
    input wire logic [7:0] char_code,
    input wire logic       last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("busy not raised after accepted beat");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result beat after last");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (busy || last))
        else $error("result beat outside a conversion");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((char_code == sidc_pkg::CHAR_MINUS && !last) ||
                    (char_code >= sidc_pkg::CHAR_ZERO &&
                     char_code <= (sidc_pkg::CHAR_ZERO + 8'd9))))
        else $error("bad character code");

endmodule

bind signed_int_to_decimal_chars_top sidc_checker u_sidc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for signed_int_to_decimal_chars_top: checks the decimal text of each input.
// Needs sidc_pkg and the converter RTL. An in-bench predictor queues the expected characters.
module tb_top;

    localparam int VW          = 32;
    localparam int CLK_PERIOD  = 10;
    localparam int RADIX       = 10;
    localparam int IDLE_LIMIT  = 500;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 358;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic signed [VW-1:0] value = '0;
    logic                 busy;
    logic                 strobe;
    logic [7:0]           char_code;
    logic                 last;

    char_beat_t expected_chars[$];
    int         err_cnt = 0;
    int         idle_cycles = 0;
    int         gap_max = 12;

    signed_int_to_decimal_chars_top #(
        .VALUE_WIDTH(VW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .busy     (busy),
        .strobe   (strobe),
        .char_code(char_code),
        .last     (last)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // expected text: optional minus, then digits most significant first
    function automatic void push_decimal_text(input logic [VW-1:0] raw);
        logic            neg;
        logic [VW-1:0]   mag_bits;
        longint unsigned mag;
        int              digs[$];
        char_beat_t      beat;
        neg      = raw[VW-1];
        mag_bits = neg ? (~raw + 1'b1) : raw;
        mag      = mag_bits;
        do
        begin
            digs.push_front(int'(mag % RADIX));
            mag = mag / RADIX;
        end
        while (mag != 0);
        if (neg)
        begin
            beat.code = sidc_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
        end
        foreach (digs[i])
        begin
            beat.code = sidc_pkg::CHAR_ZERO + 8'(digs[i]);
            beat.last = (i == digs.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // start stays high when the next beat follows with no gap
    task automatic send_value(input logic [VW-1:0] v);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        push_decimal_text(v);
    endtask

    task automatic test_extremes();
        longint vals[$];
        vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647, -2147483648,
                 -2147483647, 1000000000, -1000000000, 999999999};
        gap_max = 12;
        foreach (vals[i])
            send_value(VW'(vals[i]));
    endtask

    task automatic test_back_to_back();
        longint vals[$];
        vals = '{-2147483648, 2147483647, 0, 5, -5, 12345};
        gap_max = 0;
        foreach (vals[i])
            send_value(VW'(vals[i]));
    endtask

    // mostly values of a random digit count, some raw 32-bit patterns
    task automatic test_random_values(input int count);
        int            digits;
        longint        lo;
        longint        hi;
        longint        mag;
        logic [VW-1:0] v;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                gap_max = (gap_max == 0) ? 12 : 0;
            if ($urandom_range(3, 0) == 0)
                v = $urandom();
            else
            begin
                digits = $urandom_range(10, 1);
                lo = 1;
                repeat (digits - 1) lo = lo * RADIX;
                hi = lo * RADIX - 1;
                if (digits == 1)
                    lo = 0;
                if (hi > 64'd2147483648)
                    hi = 64'd2147483648;
                mag = lo + longint'($urandom_range(32'(hi - lo), 0));
                if (mag == 64'd2147483648 || $urandom_range(1, 0) == 1)
                    v = VW'(-mag);
                else
                    v = VW'(mag);
            end
            send_value(v);
        end
    endtask

    task automatic finish_run();
        @(posedge clk);
        start <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        char_beat_t exp_beat;
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            if (strobe)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected beat: char_code %0d last %0d", char_code, last);
                    err_cnt = err_cnt + 1;
                end
                else
                begin
                    exp_beat = expected_chars.pop_front();
                    if (char_code !== exp_beat.code)
                    begin
                        $error("char_code: expected %0d, actual %0d", exp_beat.code, char_code);
                        err_cnt = err_cnt + 1;
                    end
                    if (last !== exp_beat.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_beat.last, last);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_back_to_back();
        test_random_values(RANDOM_ITEMS);
        finish_run();
    end

endmodule
